// File: hdl/csf_pkg.sv
// Shared types, pattern constants and window match helpers for the
// character stuffing framer. No dependencies.
package csf_pkg;

   localparam int unsigned CELL_COUNT = 6;

   localparam logic [2:0] ESC_LEN = 3'd3;
   localparam logic [2:0] DLE_LEN = 3'd6;
   localparam logic [2:0] LAST_FLAG_IDX = 3'd5;

   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_DIFF  = 8'h20;
   localparam logic [7:0] CH_STUFF_E = 8'h45;
   localparam logic [7:0] CH_STUFF_D = 8'h44;

   // ESC is padded to the cell count; entries past ESC_LEN never match
   localparam logic [7:0] ESC_SEQ [0:5] = '{8'h45, 8'h53, 8'h43, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] STX_SEQ [0:5] = '{8'h44, 8'h4c, 8'h45, 8'h53, 8'h54, 8'h58};
   localparam logic [7:0] ETX_SEQ [0:5] = '{8'h44, 8'h4c, 8'h45, 8'h45, 8'h54, 8'h58};

   typedef struct packed {
      logic esc;
      logic stx;
      logic etx;
   } hit_type;

   typedef struct packed {
      logic       shift;
      logic       load;
      logic [2:0] wr_idx;
      logic [7:0] wr_char;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OPEN,
      PH_SCAN,
      PH_COPY,
      PH_STUFF,
      PH_CLOSE
   } phase_type;

   function automatic logic [5:0] low_mask(logic [2:0] n);
      logic [6:0] m;
      m = (7'd1 << n) - 7'd1;
      return m[5:0];
   endfunction

   // first plen held characters equal the pattern
   function automatic logic full_hit(logic [5:0] hits, logic [2:0] n, logic [2:0] plen);
      logic [5:0] need;
      need = low_mask(plen);
      return (n >= plen) && ((hits & need) == need);
   endfunction

   // all n held characters are a proper prefix of the pattern
   function automatic logic prefix_hit(logic [5:0] hits, logic [2:0] n, logic [2:0] plen);
      logic [5:0] need;
      need = low_mask(n);
      return (n != 3'd0) && (n < plen) && ((hits & need) == need);
   endfunction

   // scan of the held characters is finished
   function automatic logic scan_stop(logic [5:0] esc, logic [5:0] stx, logic [5:0] etx,
                                      logic [2:0] n, logic last);
      return (n == 3'd0) ||
             (!last && (prefix_hit(esc, n, ESC_LEN) || prefix_hit(stx, n, DLE_LEN) ||
                        prefix_hit(etx, n, DLE_LEN)));
   endfunction

   function automatic logic [7:0] to_upper(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_DIFF : c;
   endfunction

endpackage

// File: hdl/csf_cell.sv
// One lookahead cell: holds a character, shifts toward cell 0 and compares
// itself against the pattern characters at its own and the previous place.
// Depends on csf_pkg.
module csf_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                  clock,
   input  csf_pkg::cell_ctl_type ctl,
   input  logic [7:0]            nbr_char,
   output logic [7:0]            char_out,
   output csf_pkg::hit_type      hit_cur,
   output csf_pkg::hit_type      hit_nxt
);

   logic [7:0] char_ff;
   logic [7:0] char_in;

   always_comb begin
      char_in = char_ff;
      if (ctl.load && ctl.wr_idx == 3'(IDX)) begin
         char_in = ctl.wr_char;
      end else if (ctl.shift) begin
         char_in = nbr_char;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign char_out = char_ff;

   assign hit_cur.esc = (IDX < 3) && (char_ff == csf_pkg::ESC_SEQ[IDX]);
   assign hit_cur.stx = (char_ff == csf_pkg::STX_SEQ[IDX]);
   assign hit_cur.etx = (char_ff == csf_pkg::ETX_SEQ[IDX]);

   // compare against the pattern one place back: the view after a shift
   generate
      if (IDX == 0) begin : g_head
         assign hit_nxt = '0;
      end else begin : g_body
         assign hit_nxt.esc = (IDX < 4) && (char_ff == csf_pkg::ESC_SEQ[IDX - 1]);
         assign hit_nxt.stx = (char_ff == csf_pkg::STX_SEQ[IDX - 1]);
         assign hit_nxt.etx = (char_ff == csf_pkg::ETX_SEQ[IDX - 1]);
      end
   endgenerate

endmodule

// File: hdl/char_stuffing_framer_unit.sv
// Character stuffing framer, top level: input stage, row of lookahead cells,
// sequencer and output register. Depends on csf_pkg and csf_cell.
//
// Usage: req_ beats carry one payload character (forced to upper case) and
// a frame_last mark. Each frame opens with DLESTX; a whole ESC is followed
// by an extra E, a whole DLESTX or DLEETX by an extra D, and the beat marked
// frame_last flushes the held characters and closes with DLEETX.
// rsp_ beats carry one character each; rsp_run_last marks the last beat
// caused by an input beat, rsp_frame_end the final X of the closing flag.
// Path: an accepted beat passes the input stage, is loaded into the cell
// row, and its first result is registered in the output register.
// Throughput: the sequencer sends one character per cycle while the output
// register is free, after each beat is loaded into the cell row. Stuffing
// and flags add characters; a beat that only extends a held prefix gives no result.
// A one-entry input stage lets the next beat be accepted while the current
// one is still being sent. When the receiver stalls, the output register
// holds its beat and the sequencer waits.
// Reset (synchronous, active high) empties the window, closes any frame and
// drops pending beats.
module char_stuffing_framer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_frame_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   localparam int unsigned NC = csf_pkg::CELL_COUNT;

   // input stage
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_char_ff;
   logic       stage_last_ff;

   // sequencer state
   csf_pkg::phase_type phase_ff, phase_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] fidx_ff, fidx_in;
   logic [2:0] copy_ff, copy_in;
   logic       stuff_d_ff, stuff_d_in;
   logic       last_ff, last_in;
   logic       in_frame_ff, in_frame_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_rl_ff, out_rl_in;
   logic       out_fe_ff, out_fe_in;

   logic       accept, take, out_free, emit;
   logic [7:0] emit_char;
   logic       emit_rl, emit_fe;

   csf_pkg::cell_ctl_type ctl;
   logic [7:0]       cell_char [NC];
   csf_pkg::hit_type hit_cur [NC];
   csf_pkg::hit_type hit_nxt [NC];
   logic [5:0] cur_esc, cur_stx, cur_etx;
   logic [5:0] sh_esc, sh_stx, sh_etx;
   logic       stop_cur, stop_sh;
   logic [2:0] cnt_dec;
   csf_pkg::phase_type done_phase;

   // cell row
   genvar gi;
   generate
      for (gi = 0; gi < NC; gi++) begin : g_cell
         logic [7:0] nbr;
         if (gi == NC - 1) begin : g_tail
            assign nbr = 8'h00;
         end else begin : g_link
            assign nbr = cell_char[gi + 1];
         end
         csf_cell #(.IDX(gi)) u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .nbr_char (nbr),
            .char_out (cell_char[gi]),
            .hit_cur  (hit_cur[gi]),
            .hit_nxt  (hit_nxt[gi])
         );
         assign cur_esc[gi] = hit_cur[gi].esc;
         assign cur_stx[gi] = hit_cur[gi].stx;
         assign cur_etx[gi] = hit_cur[gi].etx;
         if (gi == NC - 1) begin : g_sh_tail
            assign sh_esc[gi] = 1'b0;
            assign sh_stx[gi] = 1'b0;
            assign sh_etx[gi] = 1'b0;
         end else begin : g_sh_body
            assign sh_esc[gi] = hit_nxt[gi + 1].esc;
            assign sh_stx[gi] = hit_nxt[gi + 1].stx;
            assign sh_etx[gi] = hit_nxt[gi + 1].etx;
         end
      end
   endgenerate

   assign cnt_dec  = cnt_ff - 3'd1;
   assign stop_cur = csf_pkg::scan_stop(cur_esc, cur_stx, cur_etx, cnt_ff, last_ff);
   assign stop_sh  = csf_pkg::scan_stop(sh_esc, sh_stx, sh_etx, cnt_dec, last_ff);
   assign done_phase = last_ff ? csf_pkg::PH_CLOSE : csf_pkg::PH_IDLE;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign take      = stage_valid_ff && (phase_ff == csf_pkg::PH_IDLE);
   assign req_stall = stage_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   // sequencer
   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      fidx_in     = fidx_ff;
      copy_in     = copy_ff;
      stuff_d_in  = stuff_d_ff;
      last_in     = last_ff;
      in_frame_in = in_frame_ff;
      ctl         = '0;
      ctl.wr_idx  = cnt_ff;
      ctl.wr_char = stage_char_ff;
      emit        = 1'b0;
      emit_char   = cell_char[0];
      emit_rl     = 1'b0;
      emit_fe     = 1'b0;
      case (phase_ff)
         csf_pkg::PH_IDLE: begin
            if (take) begin
               ctl.load = 1'b1;
               cnt_in   = cnt_ff + 3'd1;
               last_in  = stage_last_ff;
               fidx_in  = 3'd0;
               if (!in_frame_ff) begin
                  in_frame_in = 1'b1;
                  phase_in    = csf_pkg::PH_OPEN;
               end else begin
                  phase_in = csf_pkg::PH_SCAN;
               end
            end
         end
         csf_pkg::PH_OPEN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = csf_pkg::STX_SEQ[fidx_ff];
               if (fidx_ff == csf_pkg::LAST_FLAG_IDX) begin
                  fidx_in  = 3'd0;
                  emit_rl  = !last_ff && stop_cur;
                  phase_in = emit_rl ? csf_pkg::PH_IDLE : csf_pkg::PH_SCAN;
               end else begin
                  fidx_in = fidx_ff + 3'd1;
               end
            end
         end
         csf_pkg::PH_SCAN: begin
            if (stop_cur) begin
               fidx_in  = 3'd0;
               phase_in = done_phase;
            end else if (out_free) begin
               emit      = 1'b1;
               ctl.shift = 1'b1;
               cnt_in    = cnt_dec;
               if (csf_pkg::full_hit(cur_esc, cnt_ff, csf_pkg::ESC_LEN)) begin
                  copy_in    = csf_pkg::ESC_LEN - 3'd1;
                  stuff_d_in = 1'b0;
                  phase_in   = csf_pkg::PH_COPY;
               end else if (csf_pkg::full_hit(cur_stx, cnt_ff, csf_pkg::DLE_LEN) ||
                            csf_pkg::full_hit(cur_etx, cnt_ff, csf_pkg::DLE_LEN)) begin
                  copy_in    = csf_pkg::DLE_LEN - 3'd1;
                  stuff_d_in = 1'b1;
                  phase_in   = csf_pkg::PH_COPY;
               end else begin
                  emit_rl = !last_ff && stop_sh;
                  if (stop_sh) begin
                     fidx_in  = 3'd0;
                     phase_in = done_phase;
                  end
               end
            end
         end
         csf_pkg::PH_COPY: begin
            if (out_free) begin
               emit      = 1'b1;
               ctl.shift = 1'b1;
               cnt_in    = cnt_dec;
               copy_in   = copy_ff - 3'd1;
               if (copy_ff == 3'd1) begin
                  phase_in = csf_pkg::PH_STUFF;
               end
            end
         end
         csf_pkg::PH_STUFF: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = stuff_d_ff ? csf_pkg::CH_STUFF_D : csf_pkg::CH_STUFF_E;
               emit_rl   = !last_ff && stop_cur;
               if (stop_cur) begin
                  fidx_in  = 3'd0;
                  phase_in = done_phase;
               end else begin
                  phase_in = csf_pkg::PH_SCAN;
               end
            end
         end
         csf_pkg::PH_CLOSE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = csf_pkg::ETX_SEQ[fidx_ff];
               if (fidx_ff == csf_pkg::LAST_FLAG_IDX) begin
                  emit_rl     = 1'b1;
                  emit_fe     = 1'b1;
                  fidx_in     = 3'd0;
                  cnt_in      = 3'd0;
                  in_frame_in = 1'b0;
                  phase_in    = csf_pkg::PH_IDLE;
               end else begin
                  fidx_in = fidx_ff + 3'd1;
               end
            end
         end
         default: begin
            phase_in = csf_pkg::PH_IDLE;
         end
      endcase
   end

   always_comb begin
      stage_valid_in = accept ? 1'b1 : (take ? 1'b0 : stage_valid_ff);
      out_valid_in   = emit ? 1'b1 : (out_valid_ff && rsp_stall);
      out_char_in    = emit ? emit_char : out_char_ff;
      out_rl_in      = emit ? emit_rl : out_rl_ff;
      out_fe_in      = emit ? emit_fe : out_fe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         phase_ff       <= csf_pkg::PH_IDLE;
         cnt_ff         <= 3'd0;
         fidx_ff        <= 3'd0;
         copy_ff        <= 3'd0;
         last_ff        <= 1'b0;
         in_frame_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         phase_ff       <= phase_in;
         cnt_ff         <= cnt_in;
         fidx_ff        <= fidx_in;
         copy_ff        <= copy_in;
         last_ff        <= last_in;
         in_frame_ff    <= in_frame_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_char_ff <= csf_pkg::to_upper(req_in_char);
         stage_last_ff <= req_frame_last;
      end
      stuff_d_ff  <= stuff_d_in;
      out_char_ff <= out_char_in;
      out_rl_ff   <= out_rl_in;
      out_fe_ff   <= out_fe_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_run_last  = out_rl_ff;
   assign rsp_frame_end = out_fe_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd6)
      else $error("window count beyond cell row");

   a_idle_no_frame_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == csf_pkg::PH_IDLE && !in_frame_ff) |-> cnt_ff == 3'd0)
      else $error("characters held outside a frame");

   a_close_empty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == csf_pkg::PH_CLOSE |-> cnt_ff == 3'd0 && last_ff)
      else $error("closing flag with characters still held");

   a_open_one: assert property (@(posedge clock) disable iff (reset)
      phase_ff == csf_pkg::PH_OPEN |-> cnt_ff == 3'd1)
      else $error("opening flag without exactly one held character");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_run_last)
      else $error("frame end beat not marked as run last");
`endif

endmodule
